@@ design/pru_pkg.sv @@
// Package for the pixel replication upscaler: widths, codes and the structs
// passed between the configuration, control and top-level modules.
// No dependencies.
`default_nettype none

package pru_pkg;

  localparam int MAX_DIM       = 256;
  localparam int MAX_CLAMP_EXP = 4;
  localparam int DIM_W         = $clog2(MAX_DIM) + 1;
  localparam int ADDR_W        = $clog2(MAX_DIM);
  localparam int EXP_W         = 4;
  localparam int PIX_W         = 8;
  localparam int CFG_IDX_W     = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REQ_EXPONENT  = 2'd2;

  // Request function codes
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_PULL = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BUSY  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Clamped geometry and effective scale, derived from the config registers
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [EXP_W-1:0] exp;
    logic [DIM_W-1:0] reps;
  } scale_t;

  // Line store access issued by the control logic
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [PIX_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // Per-request result flags
  typedef struct packed {
    status_t status;
    logic    pull_ok;
    logic    row_done;
    logic    img_done;
  } res_meta_t;

endpackage

`default_nettype wire

@@ design/pixel_replication_upscaler_top.sv @@
// Top level of the pixel replication upscaler: request and result channels,
// config port, two-stage result pipeline. Depends on pru_pkg, pru_scale,
// pru_ctrl and pru_line_store.
//
//   channel   direction  handshake            payload
//   in_       request    in_valid / in_ready  in_func, in_pixel_in
//   out_      result     out_valid/out_ready  pixel, status, flags, exponent
//   cfg_      config     cfg_wr_en            cfg_index, cfg_data
//
// One request is taken every cycle while in_ready is high; its result passes
// through the registered line store read and then the output register.
// Counter updates happen at the accepting edge, so requests chain at full rate.
// Reset (synchronous, rst_n low) clears counters, pipeline valids and loads
// config defaults 1/1/1; the line store is not cleared and needs no sweep.
// When out_ready is low the output holds; the read stage still takes one more
// request, then in_ready drops until the output drains.
`default_nettype none

module pixel_replication_upscaler_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_func,
  input  wire logic [7:0]                    in_pixel_in,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [7:0]                         out_pixel_out,
  output logic [1:0]                         out_status,
  output logic                               out_row_block_done,
  output logic                               out_image_done,
  output logic [3:0]                         out_exponent_used,
  input  wire logic                          cfg_wr_en,
  input  wire logic [pru_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pru_pkg::DIM_W-1:0]     cfg_data
);

  pru_pkg::scale_t    scale;
  pru_pkg::mem_req_t  mem_req;
  pru_pkg::res_meta_t meta;
  logic [pru_pkg::PIX_W-1:0] rd_data;
  logic accept;

  // Read stage: meta travels alongside the registered line store read
  logic                      s1_valid_r;
  pru_pkg::res_meta_t        s1_meta_r;
  logic [pru_pkg::EXP_W-1:0] s1_exp_r;
  logic                      s1_adv;

  // Output register
  logic                      out_valid_r;
  logic [pru_pkg::PIX_W-1:0] out_pixel_r;
  pru_pkg::status_t          out_status_r;
  logic                      out_row_done_r;
  logic                      out_img_done_r;
  logic [pru_pkg::EXP_W-1:0] out_exp_r;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_valid && in_ready;

  pru_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .scale     (scale)
  );

  pru_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .func     (in_func),
    .pixel_in (in_pixel_in),
    .scale    (scale),
    .mem_req  (mem_req),
    .meta     (meta)
  );

  pru_line_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) s1_valid_r <= 1'b1;
      else if (s1_adv) s1_valid_r <= 1'b0;

      if (s1_adv) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Payload: capture at accept, advance to the output when it frees up
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta_r <= meta;
      s1_exp_r  <= scale.exp;
    end
    if (s1_adv) begin
      out_pixel_r    <= s1_meta_r.pull_ok ? rd_data : '0;
      out_status_r   <= s1_meta_r.status;
      out_row_done_r <= s1_meta_r.row_done;
      out_img_done_r <= s1_meta_r.img_done;
      out_exp_r      <= s1_exp_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pixel_out      = out_pixel_r;
  assign out_status         = out_status_r;
  assign out_row_block_done = out_row_done_r;
  assign out_image_done     = out_img_done_r;
  assign out_exponent_used  = out_exp_r;

endmodule

`default_nettype wire

@@ design/pru_scale.sv @@
// Configuration registers and effective scale derivation.
// Depends on pru_pkg.
`default_nettype none

module pru_scale (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [pru_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pru_pkg::DIM_W-1:0]     cfg_data,
  output pru_pkg::scale_t                    scale
);

  logic [pru_pkg::DIM_W-1:0] src_width_r;
  logic [pru_pkg::DIM_W-1:0] src_height_r;
  logic [pru_pkg::EXP_W-1:0] req_exp_r;

  function automatic logic [pru_pkg::DIM_W-1:0] clamp_dim(input logic [pru_pkg::DIM_W-1:0] d);
    logic [pru_pkg::DIM_W-1:0] r;
    if (d == '0) r = pru_pkg::DIM_W'(1);
    else if (32'(d) > pru_pkg::MAX_DIM) r = pru_pkg::DIM_W'(pru_pkg::MAX_DIM);
    else r = d;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= pru_pkg::DIM_W'(1);
      src_height_r <= pru_pkg::DIM_W'(1);
      req_exp_r    <= pru_pkg::EXP_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pru_pkg::CFG_SOURCE_WIDTH:  src_width_r  <= cfg_data;
        pru_pkg::CFG_SOURCE_HEIGHT: src_height_r <= cfg_data;
        pru_pkg::CFG_REQ_EXPONENT:  req_exp_r    <= cfg_data[pru_pkg::EXP_W-1:0];
        default: ;
      endcase
    end
  end

  logic [pru_pkg::DIM_W-1:0] w_c, h_c, big_c;
  logic [pru_pkg::EXP_W-1:0] best_c, exp_c;

  always_comb begin
    w_c   = clamp_dim(src_width_r);
    h_c   = clamp_dim(src_height_r);
    big_c = (w_c > h_c) ? w_c : h_c;
    // Largest clamp exponent whose scaled size still fits; zero always fits.
    best_c = '0;
    for (int e = 0; e <= pru_pkg::MAX_CLAMP_EXP; e++) begin
      if (32'(big_c) <= (pru_pkg::MAX_DIM >> e)) best_c = pru_pkg::EXP_W'(e);
    end
    exp_c = (32'(big_c) <= (pru_pkg::MAX_DIM >> req_exp_r)) ? req_exp_r : best_c;

    scale.width  = w_c;
    scale.height = h_c;
    scale.exp    = exp_c;
    scale.reps   = pru_pkg::DIM_W'(1) << exp_c;
  end

endmodule

`default_nettype wire

@@ design/pru_ctrl.sv @@
// Fill and replay counters: decide each request's outcome and the line
// store access. Depends on pru_pkg.
`default_nettype none

module pru_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      accept,
  input  wire logic                      func,
  input  wire logic [pru_pkg::PIX_W-1:0] pixel_in,
  input  pru_pkg::scale_t                scale,
  output pru_pkg::mem_req_t              mem_req,
  output pru_pkg::res_meta_t             meta
);

  logic [pru_pkg::DIM_W-1:0]  fill_col_r, fill_col_nxt;
  logic                       row_ready_r, row_ready_nxt;
  logic [pru_pkg::ADDR_W-1:0] rd_col_r, rd_col_nxt;
  logic [pru_pkg::ADDR_W-1:0] hrep_r, hrep_nxt;
  logic [pru_pkg::ADDR_W-1:0] vrep_r, vrep_nxt;
  logic [pru_pkg::ADDR_W-1:0] src_row_r, src_row_nxt;

  logic [pru_pkg::DIM_W-1:0] fill_inc, rd_inc, h_inc, v_inc, row_inc;

  always_comb begin
    fill_inc = fill_col_r + pru_pkg::DIM_W'(1);
    rd_inc   = {1'b0, rd_col_r} + pru_pkg::DIM_W'(1);
    h_inc    = {1'b0, hrep_r} + pru_pkg::DIM_W'(1);
    v_inc    = {1'b0, vrep_r} + pru_pkg::DIM_W'(1);
    row_inc  = {1'b0, src_row_r} + pru_pkg::DIM_W'(1);

    fill_col_nxt  = fill_col_r;
    row_ready_nxt = row_ready_r;
    rd_col_nxt    = rd_col_r;
    hrep_nxt      = hrep_r;
    vrep_nxt      = vrep_r;
    src_row_nxt   = src_row_r;

    mem_req.we    = 1'b0;
    mem_req.waddr = fill_col_r[pru_pkg::ADDR_W-1:0];
    mem_req.wdata = pixel_in;
    mem_req.re    = 1'b0;
    mem_req.raddr = rd_col_r;

    meta.status   = pru_pkg::ST_OK;
    meta.pull_ok  = 1'b0;
    meta.row_done = 1'b0;
    meta.img_done = 1'b0;

    if (func == pru_pkg::FUNC_PUSH) begin
      if (row_ready_r) begin
        meta.status = pru_pkg::ST_BUSY;
      end else begin
        mem_req.we   = accept && !fill_col_r[pru_pkg::DIM_W-1];
        fill_col_nxt = fill_inc;
        // Row complete: arm the replay
        if (fill_inc >= scale.width) begin
          fill_col_nxt  = '0;
          row_ready_nxt = 1'b1;
          rd_col_nxt    = '0;
          hrep_nxt      = '0;
          vrep_nxt      = '0;
        end
      end
    end else begin
      if (!row_ready_r) begin
        meta.status = pru_pkg::ST_EMPTY;
      end else begin
        mem_req.re   = accept;
        meta.pull_ok = 1'b1;
        hrep_nxt     = h_inc[pru_pkg::ADDR_W-1:0];
        if (h_inc >= scale.reps) begin
          hrep_nxt   = '0;
          rd_col_nxt = rd_inc[pru_pkg::ADDR_W-1:0];
          if (rd_inc >= scale.width) begin
            rd_col_nxt = '0;
            vrep_nxt   = v_inc[pru_pkg::ADDR_W-1:0];
            if (v_inc >= scale.reps) begin
              vrep_nxt      = '0;
              row_ready_nxt = 1'b0;
              meta.row_done = 1'b1;
              src_row_nxt   = row_inc[pru_pkg::ADDR_W-1:0];
              if (row_inc >= scale.height) begin
                src_row_nxt   = '0;
                meta.img_done = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_col_r  <= '0;
      row_ready_r <= 1'b0;
      rd_col_r    <= '0;
      hrep_r      <= '0;
      vrep_r      <= '0;
      src_row_r   <= '0;
    end else if (accept) begin
      fill_col_r  <= fill_col_nxt;
      row_ready_r <= row_ready_nxt;
      rd_col_r    <= rd_col_nxt;
      hrep_r      <= hrep_nxt;
      vrep_r      <= vrep_nxt;
      src_row_r   <= src_row_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/pru_line_store.sv @@
// One-row line store: single write port, single registered read port.
// Depends on pru_pkg.
`default_nettype none

module pru_line_store (
  input  wire logic                      clk,
  input  pru_pkg::mem_req_t              mem_req,
  output logic [pru_pkg::PIX_W-1:0]      rd_data
);

  logic [pru_pkg::PIX_W-1:0] mem_r [pru_pkg::MAX_DIM];
  logic [pru_pkg::PIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_req.we) mem_r[mem_req.waddr] <= mem_req.wdata;
  end

  // Hold read data until the next read so a stalled pipeline keeps it
  always_ff @(posedge clk) begin
    if (mem_req.re) rd_data_r <= mem_r[mem_req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ design/pru_checker.sv @@
// Port-level checks for the pixel replication upscaler, bound to the top.
// Depends on pru_pkg and pixel_replication_upscaler_top.
`default_nettype none

module pru_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_pixel_out,
  input wire logic [1:0] out_status,
  input wire logic       out_row_block_done,
  input wire logic       out_image_done,
  input wire logic [3:0] out_exponent_used
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_out) &&
      $stable(out_status) && $stable(out_row_block_done) && $stable(out_image_done))
    else $error("result changed while stalled");

  a_fail_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != pru_pkg::ST_OK |->
      out_pixel_out == '0 && !out_row_block_done && !out_image_done)
    else $error("refused or empty result carries data");

  a_img_implies_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_image_done |-> out_row_block_done)
    else $error("image end without row block end");

  a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_exponent_used <= 4'd8)
    else $error("exponent out of range");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind pixel_replication_upscaler_top pru_checker u_pru_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_pixel_out      (out_pixel_out),
  .out_status         (out_status),
  .out_row_block_done (out_row_block_done),
  .out_image_done     (out_image_done),
  .out_exponent_used  (out_exponent_used)
);

`default_nettype wire
